FILE: rtl/dsp_pkg.sv
package dsp_pkg;

	localparam int MAX_NODES    = 16;
	localparam int MAX_EDGES    = 32;
	localparam int NODE_W       = $clog2(MAX_NODES);
	localparam int NCNT_W       = $clog2(MAX_NODES + 1);
	localparam int EDGE_AW      = $clog2(MAX_EDGES);
	localparam int ECNT_W       = $clog2(MAX_EDGES + 1);
	localparam int DIST_W       = 16;
	localparam int WEIGHT_W     = 8;
	localparam int MODE_W       = 2;
	localparam int NODE_COUNT_W = 5;

	localparam int IN_TDATA_W   = 24;
	localparam int OUT_TDATA_W  = 32;
	localparam int CFG_AW       = 3;
	localparam int CFG_DW       = 32;

	localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	localparam logic REG_NODE_COUNT = 1'b0;
	localparam logic REG_UNREACH    = 1'b1;

	localparam logic [NODE_COUNT_W-1:0] RST_NODE_COUNT = 5'd16;
	localparam logic [DIST_W-1:0]       RST_UNREACH    = 16'd10000;

	typedef struct packed {
		logic [NODE_COUNT_W-1:0] node_count;
		logic [DIST_W-1:0]       unreachable_distance;
	} cfg_t;

	typedef struct packed {
		logic [IN_TDATA_W-3*NODE_W-WEIGHT_W-1:0] pad;
		logic [NODE_W-1:0]   start_node;
		logic [WEIGHT_W-1:0] edge_weight;
		logic [NODE_W-1:0]   edge_end_b;
		logic [NODE_W-1:0]   edge_end_a;
	} in_t;

	typedef struct packed {
		logic [OUT_TDATA_W-DIST_W-2*NODE_W-3:0] pad;
		logic                table_full;
		logic                has_predecessor;
		logic [NODE_W-1:0]   predecessor;
		logic [DIST_W-1:0]   distance;
		logic [NODE_W-1:0]   node_index;
	} out_t;

	typedef struct packed {
		logic [DIST_W-1:0] path_len;
		logic [NODE_W-1:0] pred;
		logic              has_pred;
	} node_t;

	typedef struct packed {
		logic                dup;
		logic [WEIGHT_W-1:0] w;
		logic [NODE_W-1:0]   b;
		logic [NODE_W-1:0]   a;
	} edge_t;

endpackage

FILE: rtl/dijkstra_shortest_paths_core.sv
// single-source shortest paths over a small undirected graph, linear-scan selection
// input stream s_*: one transfer per command (load edge, run from start node, clear table)
// output stream m_*: a load gives one reply with tlast set and table_full flagged when the
//   edge table is full; a run gives one result per node in index order, tlast on the last
// clear and the unused mode give no result
// load: a scan of the stored edges for an earlier edge on the same pair
// run: an init pass over all 16 node entries, then per selected node a selection pass and
//   a relaxation pass over the edges, a last selection pass, then the results one by one;
//   all of it bound by the single read port of the node memory and of the edge memory
// one command is worked on at a time; the next is taken once the block is back in idle,
//   even while the last result still waits in the output register
// a stalled receiver holds the output register and the run waits on it
// reset empties the edge table, restores the registers and drops any pending result;
//   the node and edge memories need no clearing
// configuration is written over the apb port at byte address 0 (node count) and 4
//   (unreachable distance); the user writes it only while idle, the block does not check
module dijkstra_shortest_paths_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dsp_pkg::CFG_AW-1:0]      paddr,
	input  logic [dsp_pkg::CFG_DW-1:0]      pwdata,
	output logic [dsp_pkg::CFG_DW-1:0]      prdata,
	output logic                            pready,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// edge_end_a, edge_end_b, edge_weight, start_node
	input  logic [dsp_pkg::IN_TDATA_W-1:0]  s_tdata,
	// mode
	input  logic [dsp_pkg::MODE_W-1:0]      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// node_index, distance, predecessor, has_predecessor, table_full
	output logic [dsp_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                            m_tlast
);
	import dsp_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_LD_SCAN  = 8'b0000_0010,
		ST_LD_FIN   = 8'b0000_0100,
		ST_INIT     = 8'b0000_1000,
		ST_SEL      = 8'b0001_0000,
		ST_RELAX    = 8'b0010_0000,
		ST_OUT_RD   = 8'b0100_0000,
		ST_OUT_WAIT = 8'b1000_0000
	} state_t;

	cfg_t   cfg;
	in_t    in_item;
	state_t state_q;

	dsp_apb_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	assign in_item = in_t'(s_tdata);

	logic [NCNT_W-1:0] n_live;
	always_comb begin
		if (cfg.node_count == '0)
			n_live = NCNT_W'(1);
		else if (cfg.node_count > NODE_COUNT_W'(MAX_NODES))
			n_live = NCNT_W'(MAX_NODES);
		else
			n_live = NCNT_W'(cfg.node_count);
	end

	// control
	logic [ECNT_W-1:0]    ecnt_q;
	logic [ECNT_W-1:0]    k_q;
	logic [NCNT_W-1:0]    i_q;
	logic                 e_vld_s1;
	logic                 s_vld_s1;
	logic                 n_vld_s2;
	logic [MAX_NODES-1:0] visited_q;
	logic                 found_q;
	logic                 dup_q;
	logic                 m_tvalid_q;

	// payload
	logic [NODE_W-1:0]   ea_q, eb_q, start_q;
	logic [WEIGHT_W-1:0] ew_q;
	logic [NCNT_W-1:0]   n_q;
	logic [NODE_W-1:0]   best_q;
	logic [DIST_W-1:0]   bestd_q;
	logic [NODE_W-1:0]   sidx_s1;
	logic [NODE_W-1:0]   other_s2;
	logic [WEIGHT_W-1:0] w_s2;
	out_t                m_tdata_q;
	logic                m_tlast_q;

	// memories
	edge_t edge_mem [MAX_EDGES];
	edge_t edge_rdata_q;
	logic  edge_we;
	edge_t edge_wdata;

	node_t             node_mem [MAX_NODES];
	node_t             node_rdata_q;
	logic              node_we;
	logic [NODE_W-1:0] node_waddr;
	node_t             node_wdata;
	logic [NODE_W-1:0] node_raddr;

	always_ff @(posedge clk) begin
		if (edge_we)
			edge_mem[ecnt_q[EDGE_AW-1:0]] <= edge_wdata;
		edge_rdata_q <= edge_mem[k_q[EDGE_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (node_we)
			node_mem[node_waddr] <= node_wdata;
		node_rdata_q <= node_mem[node_raddr];
	end

	// datapath
	logic                table_full;
	logic                out_free;
	logic                pair_match;
	logic                hit_a, hit_b;
	logic [NODE_W-1:0]   other;
	logic                relax_ok;
	logic [DIST_W:0]     sum_s2;
	logic                improve;
	logic                pick;
	logic                start_ok;
	logic                out_last;
	logic                out_load;
	out_t                out_data;

	assign table_full = (ecnt_q == ECNT_W'(MAX_EDGES));
	assign out_free   = !m_tvalid_q || m_tready;

	assign pair_match = (edge_rdata_q.a == ea_q && edge_rdata_q.b == eb_q)
		|| (edge_rdata_q.a == eb_q && edge_rdata_q.b == ea_q);

	assign hit_a    = (edge_rdata_q.a == best_q);
	assign hit_b    = (edge_rdata_q.b == best_q);
	assign other    = hit_a ? edge_rdata_q.b : edge_rdata_q.a;
	assign relax_ok = (state_q == ST_RELAX) && e_vld_s1 && (hit_a || hit_b)
		&& !edge_rdata_q.dup && ({1'b0, other} < n_q) && !visited_q[other];

	assign sum_s2  = {1'b0, bestd_q} + (DIST_W + 1)'(w_s2);
	assign improve = n_vld_s2 && (sum_s2 < {1'b0, node_rdata_q.path_len})
		&& (sum_s2 < {1'b0, cfg.unreachable_distance});

	assign pick = !visited_q[sidx_s1] && (!found_q || node_rdata_q.path_len < bestd_q);

	assign start_ok = ({1'b0, start_q} < n_q);
	assign out_last = (i_q == n_q - NCNT_W'(1));

	assign edge_we    = (state_q == ST_LD_FIN) && out_free && !table_full;
	assign edge_wdata = '{dup: dup_q, w: ew_q, b: eb_q, a: ea_q};

	assign node_raddr = (state_q == ST_RELAX) ? other : i_q[NODE_W-1:0];

	always_comb begin
		node_we    = 1'b0;
		node_waddr = i_q[NODE_W-1:0];
		node_wdata = '{path_len: cfg.unreachable_distance, pred: '0, has_pred: 1'b0};
		if (state_q == ST_INIT) begin
			node_we = 1'b1;
			if (start_ok && start_q == i_q[NODE_W-1:0])
				node_wdata.path_len = '0;
		end else if (improve) begin
			node_we    = 1'b1;
			node_waddr = other_s2;
			node_wdata = '{path_len: sum_s2[DIST_W-1:0], pred: best_q, has_pred: 1'b1};
		end
	end

	always_comb begin
		out_load = 1'b0;
		out_data = '0;
		if (state_q == ST_LD_FIN && out_free) begin
			out_load            = 1'b1;
			out_data.table_full = table_full;
		end else if (state_q == ST_OUT_WAIT && out_free) begin
			out_load                 = 1'b1;
			out_data.node_index      = i_q[NODE_W-1:0];
			out_data.distance        = node_rdata_q.path_len;
			out_data.predecessor     = node_rdata_q.pred;
			out_data.has_predecessor = node_rdata_q.has_pred;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ecnt_q     <= '0;
			k_q        <= '0;
			i_q        <= '0;
			e_vld_s1   <= 1'b0;
			s_vld_s1   <= 1'b0;
			n_vld_s2   <= 1'b0;
			visited_q  <= '0;
			found_q    <= 1'b0;
			dup_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			e_vld_s1 <= ((state_q == ST_LD_SCAN) || (state_q == ST_RELAX)) && (k_q < ecnt_q);
			s_vld_s1 <= (state_q == ST_SEL) && (i_q < n_q);
			n_vld_s2 <= relax_ok;

			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						unique case (s_tuser)
							MODE_LOAD: begin
								k_q     <= '0;
								dup_q   <= 1'b0;
								state_q <= ST_LD_SCAN;
							end
							MODE_RUN: begin
								i_q       <= '0;
								visited_q <= '0;
								state_q   <= ST_INIT;
							end
							MODE_CLEAR: ecnt_q <= '0;
							default: ;
						endcase
					end
				end
				ST_LD_SCAN: begin
					if (k_q < ecnt_q) begin
						k_q <= k_q + ECNT_W'(1);
					end else if (!e_vld_s1) begin
						state_q <= ST_LD_FIN;
					end
					if (e_vld_s1 && pair_match)
						dup_q <= 1'b1;
				end
				ST_LD_FIN: begin
					if (out_free) begin
						if (!table_full)
							ecnt_q <= ecnt_q + ECNT_W'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_INIT: begin
					if (i_q[NODE_W-1:0] == NODE_W'(MAX_NODES - 1)) begin
						i_q     <= '0;
						found_q <= 1'b0;
						state_q <= ST_SEL;
					end else begin
						i_q <= i_q + NCNT_W'(1);
					end
				end
				ST_SEL: begin
					if (i_q < n_q) begin
						i_q <= i_q + NCNT_W'(1);
					end else if (!s_vld_s1) begin
						i_q <= '0;
						if (found_q) begin
							visited_q[best_q] <= 1'b1;
							k_q               <= '0;
							state_q           <= ST_RELAX;
						end else begin
							state_q <= ST_OUT_RD;
						end
					end
					if (s_vld_s1 && pick)
						found_q <= 1'b1;
				end
				ST_RELAX: begin
					if (k_q < ecnt_q) begin
						k_q <= k_q + ECNT_W'(1);
					end else if (!e_vld_s1 && !n_vld_s2) begin
						i_q     <= '0;
						found_q <= 1'b0;
						state_q <= ST_SEL;
					end
				end
				ST_OUT_RD: state_q <= ST_OUT_WAIT;
				ST_OUT_WAIT: begin
					if (out_free) begin
						if (out_last) begin
							state_q <= ST_IDLE;
						end else begin
							i_q     <= i_q + NCNT_W'(1);
							state_q <= ST_OUT_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			ea_q    <= in_item.edge_end_a;
			eb_q    <= in_item.edge_end_b;
			ew_q    <= in_item.edge_weight;
			start_q <= in_item.start_node;
			n_q     <= n_live;
		end
		if (state_q == ST_SEL && i_q < n_q)
			sidx_s1 <= i_q[NODE_W-1:0];
		if (state_q == ST_SEL && s_vld_s1 && pick) begin
			best_q  <= sidx_s1;
			bestd_q <= node_rdata_q.path_len;
		end
		other_s2 <= other;
		w_s2     <= edge_rdata_q.w;
		if (out_load) begin
			m_tdata_q <= out_data;
			m_tlast_q <= (state_q == ST_LD_FIN) || out_last;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

FILE: rtl/dsp_apb_regs.sv
module dsp_apb_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dsp_pkg::CFG_AW-1:0]  paddr,
	input  logic [dsp_pkg::CFG_DW-1:0]  pwdata,
	output logic [dsp_pkg::CFG_DW-1:0]  prdata,
	output logic                        pready,
	output dsp_pkg::cfg_t               cfg
);
	import dsp_pkg::*;

	logic [NODE_COUNT_W-1:0] node_count_q;
	logic [DIST_W-1:0]       unreach_q;
	logic                    wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= RST_NODE_COUNT;
			unreach_q    <= RST_UNREACH;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_NODE_COUNT: node_count_q <= pwdata[NODE_COUNT_W-1:0];
				REG_UNREACH:    unreach_q    <= pwdata[DIST_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_NODE_COUNT: prdata = CFG_DW'(node_count_q);
			REG_UNREACH:    prdata = CFG_DW'(unreach_q);
		endcase
	end

	assign cfg.node_count           = node_count_q;
	assign cfg.unreachable_distance = unreach_q;

endmodule
